// File: rtl/station_table_lru_tracker_macros.svh
// Assertion macros shared by the station table RTL.
`ifndef STATION_TABLE_LRU_TRACKER_MACROS_SVH
`define STATION_TABLE_LRU_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STLT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("station table check failed");

// The consequent must hold in the cycle after the antecedent.
`define STLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("station table check failed");

`endif

// File: rtl/stlt_pkg.sv
package stlt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int SLOT_W          = 5;

  localparam logic [11:0] MIN_LEN        = 12'd16;
  localparam logic [31:0] STAMP_MAX      = 32'hFFFF_FFFF;
  localparam logic [1:0]  KIND_MGMT      = 2'd0;
  localparam logic [1:0]  KIND_DATA      = 2'd1;
  localparam logic [1:0]  FC_TYPE_MGMT   = 2'd0;
  localparam logic [3:0]  SUB_BEACON     = 4'd8;
  localparam logic [3:0]  SUB_PROBE_RESP = 4'd5;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_NEW   = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [1:0]         pkt_kind;
    logic [11:0]        frame_length;
    logic [7:0]         frame_ctrl;
    logic [47:0]        tx_address;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        time_ms;
  } frame_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    outcome_t           outcome;
    logic [31:0]        seen_count;
    logic signed [7:0]  best_dbm;
    logic               access_point;
  } result_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [47:0]        address;
    logic signed [7:0]  last_dbm;
    logic signed [7:0]  best_dbm;
    logic [31:0]        count;
    logic [31:0]        last_seen;
    logic               ap_flag;
  } entry_t;

  // Beacons and probe responses mark the sender as an access point.
  function automatic logic is_ap_frame(input logic [7:0] fc);
    return (fc[3:2] == FC_TYPE_MGMT) &&
           ((fc[7:4] == SUB_BEACON) || (fc[7:4] == SUB_PROBE_RESP));
  endfunction

endpackage

// File: rtl/stlt_ifs.sv
interface stlt_frame_if import stlt_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stlt_result_if import stlt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/station_table_lru_tracker.sv
// Channel   Direction  Carries
// frame     in         one received frame summary per request
// result    out        one table outcome per accepted frame request
// cfg       in         capture_enable write (cfg_we, cfg_wdata)
//
// A frame that passes the filter is accepted, every entry is read in turn in the
// scan state, the last read is compared in the drain state, and the result state
// writes back and loads the result; the next frame is taken only back in idle. An
// ignored frame goes from idle straight to the result state.
// Reset clears the valid bits at once; a stalled result holds the block in its
// write-back state, though a new frame is taken while an earlier result waits.

`include "station_table_lru_tracker_macros.svh"

module station_table_lru_tracker import stlt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  stlt_frame_if.sink    frame,
  stlt_result_if.source result
);

  localparam int IDXW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  // Configuration.
  logic capture_enable;

  // Sequencer.
  state_t    state, state_next;
  logic [IDXW-1:0] scan_idx;

  // The frame being worked on.
  frame_t req;
  logic   req_ignored;
  logic   req_is_ap;

  // Entry storage: valid bits in flops, the payload in a synchronous memory.
  logic [TABLE_DEPTH-1:0] entry_valid;
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q;
  logic                   rd_pend;
  logic [IDXW-1:0]        rd_idx;

  // Scan results.
  logic            hit_found;
  logic [IDXW-1:0] hit_slot;
  logic [31:0]     hit_count;
  logic signed [7:0] hit_best;
  logic            hit_ap;
  logic            free_found;
  logic [IDXW-1:0] free_slot;
  logic [31:0]     oldest;
  logic [IDXW-1:0] victim;

  // Output register.
  logic    out_valid;
  result_t out_q;

  // Write-back and result.
  logic            load;
  logic            wr_en;
  logic [IDXW-1:0] slot_sel;
  outcome_t        outcome_sel;
  entry_t          wr_entry;
  logic            frame_ok;

  assign frame.ready  = (state == ST_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_q;

  // The filter is evaluated when the frame is taken; the user is not to change the
  // configuration while a frame is in work, and the block does not enforce it.
  assign frame_ok = capture_enable &&
                    ((frame.data.pkt_kind == KIND_MGMT) ||
                     (frame.data.pkt_kind == KIND_DATA)) &&
                    (frame.data.frame_length >= MIN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_we) begin
      capture_enable <= cfg_wdata;
    end
  end

  // The result can be loaded once the output register is free or being drained.
  assign load = (state == ST_RESULT) && (!out_valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (frame.valid) begin
          state_next = frame_ok ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (scan_idx == IDXW'(TABLE_DEPTH - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      req         <= frame.data;
      req_ignored <= !frame_ok;
      req_is_ap   <= is_ap_frame(frame.data.frame_ctrl);
    end
  end

  // Memory read port: one entry a cycle during the scan.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_q   <= mem[scan_idx];
      rd_idx <= scan_idx;
    end
  end

  // Compare stage. The first matching valid entry is the hit, the first
  // invalid entry is the free slot, and the oldest stamp among valid entries
  // is the victim, the lowest index winning a tie because the test is strict.
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      oldest     <= STAMP_MAX;
      victim     <= '0;
    end else if (rd_pend) begin
      if (entry_valid[rd_idx] && (rd_q.address == req.tx_address) && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_idx;
        hit_count <= rd_q.count;
        hit_best  <= rd_q.best_dbm;
        hit_ap    <= rd_q.ap_flag;
      end
      if (!entry_valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
      if (entry_valid[rd_idx] && (rd_q.last_seen < oldest)) begin
        oldest <= rd_q.last_seen;
        victim <= rd_idx;
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      slot_sel    = hit_slot;
      outcome_sel = OUT_HIT;
    end else if (free_found) begin
      slot_sel    = free_slot;
      outcome_sel = OUT_NEW;
    end else begin
      slot_sel    = victim;
      outcome_sel = OUT_EVICT;
    end

    wr_entry.address   = req.tx_address;
    wr_entry.last_dbm  = req.signal_dbm;
    wr_entry.last_seen = req.time_ms;
    if (hit_found) begin
      wr_entry.count    = hit_count + 32'd1;
      wr_entry.best_dbm = (req.signal_dbm > hit_best) ? req.signal_dbm : hit_best;
      wr_entry.ap_flag  = hit_ap || req_is_ap;
    end else begin
      wr_entry.count    = 32'd1;
      wr_entry.best_dbm = req.signal_dbm;
      wr_entry.ap_flag  = req_is_ap;
    end
  end

  assign wr_en = load && !req_ignored;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_sel] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[slot_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (req_ignored) begin
        out_q <= '0;
      end else begin
        out_q.accepted     <= 1'b1;
        out_q.slot         <= SLOT_W'(slot_sel);
        out_q.outcome      <= outcome_sel;
        out_q.seen_count   <= wr_entry.count;
        out_q.best_dbm     <= wr_entry.best_dbm;
        out_q.access_point <= wr_entry.ap_flag;
      end
    end
  end

  `STLT_ASSERT_SAME(a_read_only_in_scan, clk, rst,
    rd_pend, (state == ST_SCAN) || (state == ST_DRAIN))
  `STLT_ASSERT_SAME(a_free_slot_is_free, clk, rst,
    (state == ST_RESULT) && !req_ignored && !hit_found && free_found,
    !entry_valid[free_slot])
  `STLT_ASSERT_SAME(a_hit_slot_is_valid, clk, rst,
    (state == ST_RESULT) && !req_ignored && hit_found, entry_valid[hit_slot])
  `STLT_ASSERT_NEXT(a_write_sets_valid, clk, rst,
    wr_en, entry_valid[$past(slot_sel)] && out_valid)

endmodule
